>>> sv/jbf_pkg.sv
// ----------------------------------------------------------------------------
// jbf_pkg
// Shared types and constants of the three-weight joint bilateral filter.
// ----------------------------------------------------------------------------
package jbf_pkg;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_CENTRE,
      ST_WINDOW,
      ST_FLUSH,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   // register indexes on the csr port
   localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_KERNEL_RADIUS = 3'd2;
   localparam logic [2:0] REG_GUIDE_COEF    = 3'd3;
   localparam logic [2:0] REG_COMPARE_COEF  = 3'd4;
   localparam logic [2:0] REG_SPATIAL_COEF  = 3'd5;

   // transaction opcodes
   localparam logic OPC_PIXEL = 1'b0;
   localparam logic OPC_DRAIN = 1'b1;

   // register reset values
   localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd1024;
   localparam logic [15:0] RST_IMAGE_HEIGHT  = 16'd1024;
   localparam logic [1:0]  RST_KERNEL_RADIUS = 2'd1;
   localparam logic [31:0] RST_GUIDE_COEF    = 32'd42949673;
   localparam logic [31:0] RST_COMPARE_COEF  = 32'd42949673;
   localparam logic [31:0] RST_SPATIAL_COEF  = 32'd429496730;

   // exp(-1/64) in Q0.32, step of the exp table recurrence
   localparam logic [31:0] EXP_STEP_Q32 = 32'd4228380000;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [10:0] image_width;
      logic [15:0] image_height;
      logic [1:0]  kernel_radius;
      logic [31:0] guide_range_coef;
      logic [31:0] compare_range_coef;
      logic [31:0] spatial_coef;
      logic        geom_write;
   } cfg_type;

endpackage

>>> sv/joint_bilateral_filter_three_weight.sv
// ----------------------------------------------------------------------------
// joint_bilateral_filter_three_weight
// Streaming joint bilateral filter with spatial, guide and source-guide weights.
// ----------------------------------------------------------------------------
// Source/guide pairs arrive in raster order and are written into a line memory
// of 2*MAX_RADIUS+1 rows. A pixel transaction that completes a window, or a
// drain transaction after the frame input, produces one filtered pixel; any
// other transaction produces no pixel. A producing transaction keeps the input
// closed after it is taken while the block does one centre read, one
// line-memory read per window position through the single read port, drains
// the weight pipeline, runs the bit-serial divider and loads the output
// register. When every weight is zero the divider is skipped. After reset the
// exp table is filled with EXP_ENTRIES entries, during which no transaction is
// accepted; csr writes are taken as ever. A finished pixel waits in an output
// register so the next transaction can be taken while it is stalled.
module joint_bilateral_filter_three_weight #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_RADIUS  = 3,
   parameter int EXP_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_src_pixel,
   input  logic [7:0]  req_guide_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_filtered_pixel,
   output logic        rsp_frame_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int RING = 2 * MAX_RADIUS + 1;
   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int RW   = $clog2(RING);
   localparam int AW   = $clog2(RING * MAX_WIDTH);
   localparam int RDW  = $clog2(MAX_RADIUS + 1);
   localparam int DXW  = RDW + 1;
   localparam int LW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
   localparam int SWW  = 16 + $clog2(RING * RING + 1);
   localparam int SSW  = SWW + 8;
   localparam int EW   = $clog2(EXP_ENTRIES);

   jbf_pkg::cfg_type   cfg;
   jbf_pkg::state_type state_ff, state_in;

   // ------------------------------------------------------------------------
   // configuration
   jbf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   logic [WW-1:0]  w_eff;
   logic [15:0]    h_eff;
   logic [RDW-1:0] r_eff;
   logic [LW-1:0]  lag;

   // effective geometry
   always_comb begin
      if (cfg.image_width == 11'd0) begin
         w_eff = WW'(1);
      end else if (int'(cfg.image_width) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg.image_width);
      end
      h_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
      if (int'(cfg.kernel_radius) > MAX_RADIUS) begin
         r_eff = RDW'(MAX_RADIUS);
      end else begin
         r_eff = RDW'(cfg.kernel_radius);
      end
      lag = LW'(int'(r_eff) * int'(w_eff) + int'(r_eff));
   end

   // ------------------------------------------------------------------------
   // exp table fill after reset
   logic [EW-1:0] fill_cnt_ff;
   logic [32:0]   fill_v_ff, fill_v_in;
   logic [16:0]   fill_round;
   logic [15:0]   fill_data;
   logic [63:0]   fill_prod;
   logic          fill_en;

   assign fill_en    = state_ff == jbf_pkg::ST_FILL;
   assign fill_round = 17'((fill_v_ff + 33'd32768) >> 16);
   assign fill_data  = fill_round[16] ? 16'hFFFF : fill_round[15:0];
   assign fill_prod  = 64'(fill_v_ff[31:0]) * 64'(jbf_pkg::EXP_STEP_Q32);
   assign fill_v_in  = fill_v_ff[32] ? {1'b0, jbf_pkg::EXP_STEP_Q32}
                                     : {1'b0, fill_prod[63:32]};

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff <= '0;
         fill_v_ff   <= 33'h1_0000_0000;
      end else if (fill_en) begin
         fill_cnt_ff <= fill_cnt_ff + EW'(1);
         fill_v_ff   <= fill_v_in;
      end
   end

   // ------------------------------------------------------------------------
   // stream counters
   logic [XW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [15:0]   in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RW-1:0] in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   logic [LW-1:0] lead_ff, lead_in, lead_tmp;
   logic          acc, emit, emit_last, line_wr;
   logic          in_done, out_pend;

   assign acc      = req_valid && req_ready;
   assign in_done  = in_row_ff >= h_eff;
   assign out_pend = out_row_ff < h_eff;

   // counter update on each transaction
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_ring_in  = in_ring_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_ring_in = out_ring_ff;
      lead_in     = lead_ff;
      lead_tmp    = lead_ff;
      emit        = 1'b0;
      emit_last   = 1'b0;
      line_wr     = 1'b0;
      if (cfg.geom_write) begin
         in_col_in   = '0;
         in_row_in   = '0;
         in_ring_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_ring_in = '0;
         lead_in     = '0;
      end else if (acc) begin
         if (req_opcode == jbf_pkg::OPC_PIXEL) begin
            if (!in_done) begin
               line_wr  = 1'b1;
               lead_tmp = lead_ff + LW'(1);
               if (int'(in_col_ff) + 1 >= int'(w_eff)) begin
                  in_col_in  = '0;
                  in_row_in  = in_row_ff + 16'd1;
                  in_ring_in = (int'(in_ring_ff) == RING - 1) ? '0 : in_ring_ff + RW'(1);
               end else begin
                  in_col_in = in_col_ff + XW'(1);
               end
               emit = (in_row_in >= h_eff) || (lead_tmp > lag);
            end
         end else begin
            emit = in_done && out_pend;
         end
         lead_in = lead_tmp;
         if (emit) begin
            lead_in = lead_tmp - LW'(1);
            if (int'(out_col_ff) + 1 >= int'(w_eff)) begin
               out_col_in  = '0;
               out_row_in  = out_row_ff + 16'd1;
               out_ring_in = (int'(out_ring_ff) == RING - 1) ? '0 : out_ring_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + XW'(1);
            end
            if (out_row_in >= h_eff) begin
               emit_last   = 1'b1;
               in_col_in   = '0;
               in_row_in   = '0;
               in_ring_in  = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               out_ring_in = '0;
               lead_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_ring_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_ring_ff <= '0;
         lead_ff     <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_ring_ff  <= in_ring_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_ring_ff <= out_ring_in;
         lead_ff     <= lead_in;
      end
   end

   // job registers: centre position of the pixel being filtered
   logic [XW-1:0] jx_ff;
   logic [15:0]   jy_ff;
   logic [RW-1:0] jring_ff;
   logic          jlast_ff;

   always_ff @(posedge clock) begin
      if (acc && emit) begin
         jx_ff    <= out_col_ff;
         jy_ff    <= out_row_ff;
         jring_ff <= out_ring_ff;
         jlast_ff <= emit_last;
      end
   end

   // ------------------------------------------------------------------------
   // window walk
   logic signed [DXW-1:0] dx_ff, dx_in, dy_ff, dy_in, r_pos;
   logic [RW-1:0]         wring_ff, wring_in;
   logic signed [XW+1:0]  xs;
   logic signed [17:0]    ys;
   logic                  in_img, win_end, pipe_empty;
   logic [AW-1:0]         line_rd_addr, line_wr_addr, centre_addr, win_addr;
   logic [15:0]           line_rd;
   int                    top_ring;

   assign r_pos        = $signed({1'b0, r_eff});
   assign xs           = $signed({2'b00, jx_ff}) + (XW+2)'(dx_ff);
   assign ys           = $signed({2'b00, jy_ff}) + 18'(dy_ff);
   assign in_img       = (xs >= 0) && (xs < $signed((XW+2)'(w_eff))) &&
                         (ys >= 0) && (ys < $signed(18'(h_eff)));
   assign win_end      = (dx_ff == r_pos) && (dy_ff == r_pos);
   assign centre_addr  = AW'(int'(jring_ff) * MAX_WIDTH + int'(jx_ff));
   assign win_addr     = AW'(int'(wring_ff) * MAX_WIDTH + int'(xs[XW-1:0]));
   assign line_wr_addr = AW'(int'(in_ring_ff) * MAX_WIDTH + int'(in_col_ff));
   assign top_ring     = int'(jring_ff) + RING - int'(r_eff);

   // window position stepping
   always_comb begin
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      wring_in = wring_ff;
      if (state_ff == jbf_pkg::ST_CENTRE) begin
         dx_in    = -r_pos;
         dy_in    = -r_pos;
         wring_in = (top_ring >= RING) ? RW'(top_ring - RING) : RW'(top_ring);
      end else if (state_ff == jbf_pkg::ST_WINDOW) begin
         if (dx_ff == r_pos) begin
            dx_in    = -r_pos;
            dy_in    = dy_ff + DXW'(1);
            wring_in = (int'(wring_ff) == RING - 1) ? '0 : wring_ff + RW'(1);
         end else begin
            dx_in = dx_ff + DXW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      wring_ff <= wring_in;
   end

   // line memory, source in the upper byte, guide in the lower
   jbf_ram #(.WIDTH(16), .DEPTH(RING * MAX_WIDTH)) u_lines (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (line_wr_addr),
      .wr_data ({req_src_pixel, req_guide_pixel}),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd)
   );

   // ------------------------------------------------------------------------
   // weight pipeline
   logic                  v1_ff, va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff;
   logic                  cen_cap_ff;
   logic [7:0]            cg_ff, cs_ff;
   logic signed [DXW-1:0] dx1_ff, dy1_ff;
   logic [RDW-1:0]        adx, ady;
   logic [7:0]            s1, g1, ag, ac;
   logic [15:0]           dg_a_ff, dc_a_ff, ds_a_ff;
   logic [7:0]            s_a_ff, s_b_ff, s_c_ff, s_d_ff, s_e_ff;
   logic [47:0]           pg_b_ff, pc_b_ff, ps_b_ff;
   logic                  okg, okc, oks, okg_c_ff, okc_c_ff, oks_c_ff;
   logic [EW-1:0]         rag, rac, ras;
   logic [15:0]           rom_g, rom_c, rom_s, eg, ec, es;
   logic [31:0]           m1_d_ff, m2;
   logic [15:0]           ec_d_ff, wt_e_ff, wt_f_ff;
   logic [23:0]           ws_f_ff;
   logic [SWW-1:0]        sw_ff;
   logic [SSW-1:0]        ss_ff;
   logic                  v0;

   assign v0  = (state_ff == jbf_pkg::ST_WINDOW) && in_img;
   assign s1  = line_rd[15:8];
   assign g1  = line_rd[7:0];
   assign ag  = (g1 > cg_ff) ? g1 - cg_ff : cg_ff - g1;
   assign ac  = (s1 > g1) ? s1 - g1 : g1 - s1;
   assign adx = RDW'((dx1_ff < 0) ? -dx1_ff : dx1_ff);
   assign ady = RDW'((dy1_ff < 0) ? -dy1_ff : dy1_ff);

   // exp table index, zero weight past the end of the table
   assign okg = {10'd0, pg_b_ff[47:26]} < 32'(EXP_ENTRIES);
   assign okc = {10'd0, pc_b_ff[47:26]} < 32'(EXP_ENTRIES);
   assign oks = {10'd0, ps_b_ff[47:26]} < 32'(EXP_ENTRIES);
   assign rag = okg ? EW'(pg_b_ff[47:26]) : '0;
   assign rac = okc ? EW'(pc_b_ff[47:26]) : '0;
   assign ras = oks ? EW'(ps_b_ff[47:26]) : '0;
   assign eg  = okg_c_ff ? rom_g : 16'd0;
   assign ec  = okc_c_ff ? rom_c : 16'd0;
   assign es  = oks_c_ff ? rom_s : 16'd0;
   assign m2  = 32'(m1_d_ff[31:16]) * 32'(ec_d_ff);

   jbf_ram #(.WIDTH(16), .DEPTH(EXP_ENTRIES)) u_exp_guide (
      .clock (clock), .wr_en (fill_en), .wr_addr (fill_cnt_ff), .wr_data (fill_data),
      .rd_addr (rag), .rd_data (rom_g)
   );
   jbf_ram #(.WIDTH(16), .DEPTH(EXP_ENTRIES)) u_exp_compare (
      .clock (clock), .wr_en (fill_en), .wr_addr (fill_cnt_ff), .wr_data (fill_data),
      .rd_addr (rac), .rd_data (rom_c)
   );
   jbf_ram #(.WIDTH(16), .DEPTH(EXP_ENTRIES)) u_exp_spatial (
      .clock (clock), .wr_en (fill_en), .wr_addr (fill_cnt_ff), .wr_data (fill_data),
      .rd_addr (ras), .rd_data (rom_s)
   );

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         va_ff      <= 1'b0;
         vb_ff      <= 1'b0;
         vc_ff      <= 1'b0;
         vd_ff      <= 1'b0;
         ve_ff      <= 1'b0;
         vf_ff      <= 1'b0;
         cen_cap_ff <= 1'b0;
      end else begin
         v1_ff      <= v0;
         va_ff      <= v1_ff;
         vb_ff      <= va_ff;
         vc_ff      <= vb_ff;
         vd_ff      <= vc_ff;
         ve_ff      <= vd_ff;
         vf_ff      <= ve_ff;
         cen_cap_ff <= state_ff == jbf_pkg::ST_CENTRE;
      end
   end

   assign pipe_empty = !(v1_ff || va_ff || vb_ff || vc_ff || vd_ff || ve_ff || vf_ff);

   // stage payloads
   always_ff @(posedge clock) begin
      if (cen_cap_ff) begin
         cg_ff <= line_rd[7:0];
         cs_ff <= line_rd[15:8];
      end
      dx1_ff   <= dx_ff;
      dy1_ff   <= dy_ff;
      // squared differences
      dg_a_ff  <= 16'(ag) * 16'(ag);
      dc_a_ff  <= 16'(ac) * 16'(ac);
      ds_a_ff  <= 16'(adx) * 16'(adx) + 16'(ady) * 16'(ady);
      s_a_ff   <= s1;
      // scaled by the coefficients
      pg_b_ff  <= 48'(dg_a_ff) * 48'(cfg.guide_range_coef);
      pc_b_ff  <= 48'(dc_a_ff) * 48'(cfg.compare_range_coef);
      ps_b_ff  <= 48'(ds_a_ff) * 48'(cfg.spatial_coef);
      s_b_ff   <= s_a_ff;
      // table lookups
      okg_c_ff <= okg;
      okc_c_ff <= okc;
      oks_c_ff <= oks;
      s_c_ff   <= s_b_ff;
      // weight products, truncated to Q0.16
      m1_d_ff  <= 32'(eg) * 32'(es);
      ec_d_ff  <= ec;
      s_d_ff   <= s_c_ff;
      wt_e_ff  <= m2[31:16];
      s_e_ff   <= s_d_ff;
      wt_f_ff  <= wt_e_ff;
      ws_f_ff  <= 24'(wt_e_ff) * 24'(s_e_ff);
   end

   // weight and weighted-source sums
   always_ff @(posedge clock) begin
      if (state_ff == jbf_pkg::ST_CENTRE) begin
         sw_ff <= '0;
         ss_ff <= '0;
      end else if (vf_ff) begin
         sw_ff <= sw_ff + SWW'(wt_f_ff);
         ss_ff <= ss_ff + SSW'(ws_f_ff);
      end
   end

   // ------------------------------------------------------------------------
   // divider
   logic       div_start, div_done;
   logic [7:0] quo;

   jbf_div #(.NUMW(SSW), .DENW(SWW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (ss_ff),
      .den   (sw_ff),
      .done  (div_done),
      .quo   (quo)
   );

   // ------------------------------------------------------------------------
   // sequencer
   logic       rsp_load, res_zero, res_div;
   logic [7:0] res_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jbf_pkg::ST_FILL:
            if (int'(fill_cnt_ff) == EXP_ENTRIES - 1) state_in = jbf_pkg::ST_IDLE;
         jbf_pkg::ST_IDLE:
            if (acc && emit && !cfg.geom_write) state_in = jbf_pkg::ST_CENTRE;
         jbf_pkg::ST_CENTRE:
            state_in = jbf_pkg::ST_WINDOW;
         jbf_pkg::ST_WINDOW:
            if (win_end) state_in = jbf_pkg::ST_FLUSH;
         jbf_pkg::ST_FLUSH:
            if (pipe_empty) begin
               state_in = (sw_ff == '0) ? jbf_pkg::ST_RESULT : jbf_pkg::ST_DIVIDE;
            end
         jbf_pkg::ST_DIVIDE:
            if (div_done) state_in = jbf_pkg::ST_RESULT;
         jbf_pkg::ST_RESULT:
            if (!rsp_valid || rsp_ready) state_in = jbf_pkg::ST_IDLE;
         default:
            state_in = jbf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = state_ff == jbf_pkg::ST_IDLE;
      line_rd_addr = (state_ff == jbf_pkg::ST_CENTRE) ? centre_addr : win_addr;
      res_zero     = (state_ff == jbf_pkg::ST_FLUSH) && pipe_empty && (sw_ff == '0);
      div_start    = (state_ff == jbf_pkg::ST_FLUSH) && pipe_empty && (sw_ff != '0);
      res_div      = (state_ff == jbf_pkg::ST_DIVIDE) && div_done;
      rsp_load     = (state_ff == jbf_pkg::ST_RESULT) && (!rsp_valid || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jbf_pkg::ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   // result value, centre source when all weights vanish
   always_ff @(posedge clock) begin
      if (res_zero) begin
         res_ff <= cs_ff;
      end else if (res_div) begin
         res_ff <= quo;
      end
   end

   // ------------------------------------------------------------------------
   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_pixel_ff;
   logic       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_ff <= res_ff;
         rsp_last_ff  <= jlast_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_pixel = rsp_pixel_ff;
   assign rsp_frame_last     = rsp_last_ff;

endmodule

>>> sv/jbf_ram.sv
// ----------------------------------------------------------------------------
// jbf_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module jbf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/jbf_div.sv
// ----------------------------------------------------------------------------
// jbf_div
// Restoring divider, one quotient bit per cycle, for an 8-bit quotient.
// ----------------------------------------------------------------------------
module jbf_div #(
   parameter int NUMW = 30,
   parameter int DENW = 22
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NUMW-1:0] num,
   input  logic [DENW-1:0] den,
   output logic            done,
   output logic [7:0]      quo
);

   logic [NUMW-1:0] rem_ff, rem_in;
   logic [NUMW-1:0] dsh_ff, dsh_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [7:0]      quo_ff, quo_in;
   logic            ge;

   // one trial subtraction per cycle, divisor shifted right each step
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      ge      = rem_ff >= dsh_ff;
      if (start) begin
         rem_in = num;
         dsh_in = NUMW'(den) << 7;
         cnt_in = 3'd7;
         run_in = 1'b1;
         quo_in = 8'd0;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[6:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> sv/jbf_csr.sv
// ----------------------------------------------------------------------------
// jbf_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module jbf_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output jbf_pkg::cfg_type    cfg
);

   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [1:0]  radius_ff;
   logic [31:0] gcoef_ff, ccoef_ff, scoef_ff;
   logic        wr;
   logic [2:0]  idx;

   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= jbf_pkg::RST_IMAGE_WIDTH;
         height_ff <= jbf_pkg::RST_IMAGE_HEIGHT;
         radius_ff <= jbf_pkg::RST_KERNEL_RADIUS;
         gcoef_ff  <= jbf_pkg::RST_GUIDE_COEF;
         ccoef_ff  <= jbf_pkg::RST_COMPARE_COEF;
         scoef_ff  <= jbf_pkg::RST_SPATIAL_COEF;
      end else if (wr) begin
         unique case (idx)
            jbf_pkg::REG_IMAGE_WIDTH:   width_ff  <= csr_pwdata[10:0];
            jbf_pkg::REG_IMAGE_HEIGHT:  height_ff <= csr_pwdata[15:0];
            jbf_pkg::REG_KERNEL_RADIUS: radius_ff <= csr_pwdata[1:0];
            jbf_pkg::REG_GUIDE_COEF:    gcoef_ff  <= csr_pwdata;
            jbf_pkg::REG_COMPARE_COEF:  ccoef_ff  <= csr_pwdata;
            jbf_pkg::REG_SPATIAL_COEF:  scoef_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         jbf_pkg::REG_IMAGE_WIDTH:   csr_prdata = {21'd0, width_ff};
         jbf_pkg::REG_IMAGE_HEIGHT:  csr_prdata = {16'd0, height_ff};
         jbf_pkg::REG_KERNEL_RADIUS: csr_prdata = {30'd0, radius_ff};
         jbf_pkg::REG_GUIDE_COEF:    csr_prdata = gcoef_ff;
         jbf_pkg::REG_COMPARE_COEF:  csr_prdata = ccoef_ff;
         jbf_pkg::REG_SPATIAL_COEF:  csr_prdata = scoef_ff;
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // geometry writes restart the frame
   always_comb begin
      cfg.image_width        = width_ff;
      cfg.image_height       = height_ff;
      cfg.kernel_radius      = radius_ff;
      cfg.guide_range_coef   = gcoef_ff;
      cfg.compare_range_coef = ccoef_ff;
      cfg.spatial_coef       = scoef_ff;
      cfg.geom_write         = wr && (idx == jbf_pkg::REG_IMAGE_WIDTH ||
                                      idx == jbf_pkg::REG_IMAGE_HEIGHT ||
                                      idx == jbf_pkg::REG_KERNEL_RADIUS);
   end

endmodule

>>> sv/jbf_checker.sv
// ----------------------------------------------------------------------------
// jbf_checker
// Port-level checks of the filter, bound to the top level.
// ----------------------------------------------------------------------------
module jbf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_filtered_pixel,
   input logic       rsp_frame_last
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // exp table fill holds off transactions after reset
   a_fill_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input ready during table fill");

   // a result never appears in the cycle after a transaction is taken
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result produced without window pass");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_filtered_pixel) &&
                                     $stable(rsp_frame_last)))
      else $error("stalled result changed");

endmodule

bind joint_bilateral_filter_three_weight jbf_checker u_jbf_checker (.*);
